// ===== design/npgr_pkg.sv =====
package npgr_pkg;

	// function codes of an input item
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_QUERY = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST  = 2'd1;
	localparam int CFG_DATA_W = 34;

	localparam int POS_W    = 16;
	localparam int DENS_W   = 32;
	localparam int CELL_W   = 8;
	localparam int GRID_W   = CELL_W + POS_W;      // cell index times step
	localparam int SQ_W     = 2 * GRID_W;          // one axis squared
	localparam int SUM_W    = SQ_W + 2;            // three axes summed
	localparam int HITS_W   = 24;
	localparam int WORD_W   = 3 * POS_W + DENS_W;  // one stored particle

	localparam logic [CFG_DATA_W-1:0] GRID_STEP_RST = 34'd1311;
	localparam logic [CFG_DATA_W-1:0] MAX_DIST_RST  = 34'd1717987;

	typedef struct packed {
		logic [1:0]        func;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic signed [DENS_W-1:0] particle_density;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [CELL_W-1:0] cell_z;
	} npgr_in_t;

	typedef struct packed {
		logic signed [DENS_W-1:0] cell_density;
		logic              hit;
		logic [HITS_W-1:0] hits_so_far;
	} npgr_out_t;

	// data that walks down the row of distance cells
	typedef struct packed {
		logic                   last;
		logic [2:0][POS_W-1:0]  pos;
		logic [DENS_W-1:0]      dens;
		logic [SUM_W-1:0]       sum;
	} npgr_flow_t;

endpackage

// ===== design/npgr_ram.sv =====
module npgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [ADDR_W-1:0]        waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [ADDR_W-1:0]        raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/npgr_axis_cell.sv =====
module npgr_axis_cell
	import npgr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [GRID_W-1:0] grid,
	input  logic              vld_in,
	input  npgr_flow_t        flow_in,
	output logic              vld_out,
	output npgr_flow_t        flow_out
);
	logic              vld_s1, vld_s2, vld_s3;
	npgr_flow_t        f_s1, f_s2, f_s3;
	logic [GRID_W-1:0] diff_s1;
	logic [SQ_W-1:0]   sq_s2;
	logic [GRID_W-1:0] coord;

	assign coord = {{CELL_W{1'b0}}, flow_in.pos[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		// absolute difference on this cell's axis
		f_s1    <= flow_in;
		diff_s1 <= (coord >= grid) ? (coord - grid) : (grid - coord);
		f_s2    <= f_s1;
		sq_s2   <= diff_s1 * diff_s1;
		// add in and rotate so the next cell sees the next axis
		f_s3.last <= f_s2.last;
		f_s3.dens <= f_s2.dens;
		f_s3.pos  <= {f_s2.pos[0], f_s2.pos[2], f_s2.pos[1]};
		f_s3.sum  <= f_s2.sum + SUM_W'(sq_s2);
	end

	assign vld_out  = vld_s3;
	assign flow_out = f_s3;

endmodule

// ===== design/nearest_particle_grid_resampler.sv =====
// nearest particle grid resampler
//
// command channel: item is taken at a rising edge with start high and busy low.
//   load (func 0) writes a particle into the next free slot of the store, if any,
//   query (func 1) looks up a grid cell, clear (func 2) empties the store and
//   the hit count; code 3 does nothing. loads, clears and code 3 never raise
//   busy.
// result channel: a query gives one result, shown for exactly one cycle with
//   done high. the receiver cannot stall it, so it must take it that cycle.
// config port: cfg_we/cfg_idx/cfg_wdata write grid_step (0) or
//   max_distance_sq (1) at once; other indexes are dropped.
// timing: a query holds busy through the scan, drain and finish states, and
//   done rises in the same cycle that busy falls. the store memory hands out one
//   particle per cycle during the scan and a row of three axis cells (three stages
//   each) turns it into a squared distance. an empty store goes straight to finish.
// reset: arst_n empties the store, zeroes the hit count and loads the
//   register reset values; the stored particles themselves are not cleared.
module nearest_particle_grid_resampler
	import npgr_pkg::*;
#(
	parameter int MAX_PARTICLES = 4096,
	parameter int GRID_DIM      = 50
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  npgr_in_t              item,
	output logic                  done,
	output npgr_out_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);
	localparam int ADDR_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
	localparam logic [HITS_W-1:0] HITS_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [POS_W-1:0]      grid_step_q;
	logic [CFG_DATA_W-1:0] max_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_step_q <= GRID_STEP_RST[POS_W-1:0];
			max_dist_q  <= MAX_DIST_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_STEP: grid_step_q <= cfg_wdata[POS_W-1:0];
				REG_MAX_DIST:  max_dist_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic              accept;
	logic              do_load;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_q;
	logic              scan_last;

	assign accept    = start && !busy;
	assign do_load   = accept && (item.func == FUNC_LOAD)
		&& (count_q < CNT_W'(MAX_PARTICLES));
	assign scan_last = (CNT_W'(addr_q) + CNT_W'(1)) == count_q;

	// particle store: {density, z, y, x}
	logic [WORD_W-1:0] rdata;

	npgr_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_PARTICLES)
	) u_store (
		.clk   (clk),
		.we    (do_load),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata ({item.particle_density, item.pos_z, item.pos_y, item.pos_x}),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// grid point of the query, clamped index times step
	logic [2:0][CELL_W-1:0] cell_in;
	logic [2:0][GRID_W-1:0] grid_d;
	logic [2:0][GRID_W-1:0] grid_q;

	assign cell_in = {item.cell_z, item.cell_y, item.cell_x};

	always_comb begin
		logic [CELL_W-1:0] c;
		for (int a = 0; a < 3; a++) begin
			c = cell_in[a];
			if ({1'b0, c} >= (CELL_W+1)'(GRID_DIM)) begin
				c = CELL_W'(GRID_DIM - 1);
			end
			grid_d[a] = GRID_W'(c) * GRID_W'(grid_step_q);
		end
	end

	// row of distance cells, one per axis
	logic       rd_vld_s1;
	logic       rd_last_s1;
	logic       chain_vld [4];
	npgr_flow_t chain     [4];

	// {last, z/y/x positions, density, zero sum}
	assign chain_vld[0] = rd_vld_s1;
	assign chain[0]     = {rd_last_s1, rdata[3*POS_W-1:0], rdata[WORD_W-1:3*POS_W],
		{SUM_W{1'b0}}};

	for (genvar k = 0; k < 3; k++) begin : g_cell
		npgr_axis_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.grid     (grid_q[k]),
			.vld_in   (chain_vld[k]),
			.flow_in  (chain[k]),
			.vld_out  (chain_vld[k+1]),
			.flow_out (chain[k+1])
		);
	end

	// running minimum at the end of the row
	logic              found_q;
	logic [SUM_W-1:0]  best_q;
	logic [DENS_W-1:0] best_dens_q;
	logic [HITS_W-1:0] hit_cnt_q;
	logic              hit;
	logic              take;

	// strict less-than keeps the earliest particle on a tie
	assign take = chain_vld[3] && (!found_q || (chain[3].sum < best_q));
	assign hit  = found_q && (best_q <= SUM_W'(max_dist_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			hit_cnt_q   <= '0;
			grid_q      <= '0;
			found_q     <= 1'b0;
			best_q      <= '0;
			best_dens_q <= '0;
			rd_vld_s1   <= 1'b0;
			rd_last_s1  <= 1'b0;
			done        <= 1'b0;
			result      <= '0;
		end else begin
			done       <= (state_q == S_FINISH);
			rd_vld_s1  <= (state_q == S_SCAN);
			rd_last_s1 <= scan_last;
			if (take) begin
				found_q     <= 1'b1;
				best_q      <= chain[3].sum;
				best_dens_q <= chain[3].dens;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (item.func)
							FUNC_LOAD: begin
								if (do_load) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							FUNC_QUERY: begin
								grid_q  <= grid_d;
								found_q <= 1'b0;
								addr_q  <= '0;
								state_q <= (count_q == '0) ? S_FINISH : S_SCAN;
							end
							FUNC_CLEAR: begin
								count_q   <= '0;
								hit_cnt_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + ADDR_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (chain_vld[3] && chain[3].last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					result.hit          <= hit;
					result.cell_density <= hit ? best_dens_q : '0;
					if (hit && (hit_cnt_q != HITS_MAX)) begin
						hit_cnt_q          <= hit_cnt_q + HITS_W'(1);
						result.hits_so_far <= hit_cnt_q + HITS_W'(1);
					end else begin
						result.hits_so_far <= hit_cnt_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// ===== design/npgr_checker.sv =====
module npgr_checker
	import npgr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input npgr_in_t              item,
	input logic                  done,
	input npgr_out_t             result,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata
);
	// a result only closes a busy query
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result without a query in flight");

	// a miss never carries a density
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.cell_density == '0))
		else $error("miss with nonzero density");

	// an accepted query raises busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.func == FUNC_QUERY)) |=> busy)
		else $error("query transfer did not raise busy");

	// a hit always leaves a nonzero count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.hits_so_far != '0))
		else $error("hit with zero hit count");

endmodule

bind nearest_particle_grid_resampler npgr_checker u_npgr_checker (.*);
